// ===== design/hrp_pkg.sv =====
// ----------------------------------------------------------------------------
// hrp_pkg
// Shared types and codes for the hex record character parser.
// ----------------------------------------------------------------------------
`default_nettype none

package hrp_pkg;

    localparam logic [2:0] K_DATA  = 3'd0;
    localparam logic [2:0] K_OK    = 3'd1;
    localparam logic [2:0] K_CSUM  = 3'd2;
    localparam logic [2:0] K_START = 3'd3;
    localparam logic [2:0] K_HEX   = 3'd4;
    localparam logic [2:0] K_SHORT = 3'd5;
    localparam logic [2:0] K_EOF   = 3'd6;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam logic [7:0] TYPE_DATA = 8'h00;
    localparam logic [7:0] TYPE_EOF  = 8'h01;
    localparam logic [7:0] TYPE_SEG  = 8'h02;
    localparam logic [7:0] TYPE_LIN  = 8'h04;

    typedef struct packed {
        logic       is_space;
        logic       is_colon;
        logic       is_lf;
        logic       is_hex;
        logic [3:0] nibble;
    } t_char_class;

endpackage

`default_nettype wire

// ===== design/hex_record_char_parser.sv =====
// ----------------------------------------------------------------------------
// hex_record_char_parser
// Intel HEX text parser, one character per item; emits data bytes with
// absolute addresses and a status item at the end of every record.
//
//   channel | direction | handshake          | payload
//   in      | to block  | i_valid / o_stall  | i_character
//   out     | from block| o_valid / i_stall  | o_kind o_address o_data_byte
//           |           |                    | o_record_type o_byte_count
//
// One item per cycle while o_stall is low; a result appears in the cycle after its item is taken.
// The parse state and the result register update in the same cycle.
// i_rst_n is synchronous; after reset the parser waits between records.
// o_stall rises only while a result is held and the sink stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module hex_record_char_parser
    import hrp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic [7:0]  i_character,
    output logic             o_stall,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_kind,
    output logic [31:0]      o_address,
    output logic [7:0]       o_data_byte,
    output logic [7:0]       o_record_type,
    output logic [7:0]       o_byte_count
);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_COUNT = 3'd1;
    localparam logic [2:0] PH_ADDRH = 3'd2;
    localparam logic [2:0] PH_ADDRL = 3'd3;
    localparam logic [2:0] PH_TYPE  = 3'd4;
    localparam logic [2:0] PH_DATA  = 3'd5;
    localparam logic [2:0] PH_CHECK = 3'd6;
    localparam logic [2:0] PH_SKIP  = 3'd7;

    t_char_class cls;

    logic [2:0]  r_phase,      n_phase;
    logic [3:0]  r_high,       n_high;
    logic        r_pending,    n_pending;
    logic [7:0]  r_count,      n_count;
    logic [15:0] r_offset,     n_offset;
    logic [7:0]  r_type,       n_type;
    logic [7:0]  r_done,       n_done;
    logic [7:0]  r_sum,        n_sum;
    logic [31:0] r_base,       n_base;
    logic [15:0] r_first,      n_first;
    logic        r_stopped,    n_stopped;

    logic        r_out_valid;
    logic [2:0]  r_kind;
    logic [31:0] r_address;
    logic [7:0]  r_data_byte;
    logic [7:0]  r_rtype;
    logic [7:0]  r_bcount;

    logic        accept;
    logic        emit;
    logic [2:0]  e_kind;
    logic [31:0] e_address;
    logic [7:0]  e_data;
    logic        e_fields;
    logic [31:0] rec_base;
    logic [7:0]  byte_val;
    logic [7:0]  done_inc;

    hrp_char_class u_class (
        .i_character (i_character),
        .o_class     (cls)
    );

    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;
    assign rec_base = r_base + {16'h0000, r_offset};
    assign byte_val = {r_high, cls.nibble};
    assign done_inc = r_done + 8'd1;

    always_comb begin
        n_phase   = r_phase;
        n_high    = r_high;
        n_pending = r_pending;
        n_count   = r_count;
        n_offset  = r_offset;
        n_type    = r_type;
        n_done    = r_done;
        n_sum     = r_sum;
        n_base    = r_base;
        n_first   = r_first;
        n_stopped = r_stopped;
        emit      = 1'b0;
        e_kind    = K_OK;
        e_address = rec_base;
        e_data    = 8'h00;
        e_fields  = 1'b1;

        if (r_stopped) begin
            // idle until reset
        end else if (r_phase == PH_IDLE) begin
            if (cls.is_colon) begin
                n_phase   = PH_COUNT;
                n_high    = 4'h0;
                n_pending = 1'b0;
                n_count   = 8'h00;
                n_offset  = 16'h0000;
                n_type    = 8'h00;
                n_done    = 8'h00;
                n_sum     = 8'h00;
                n_first   = 16'h0000;
            end else if (!cls.is_space) begin
                n_phase   = PH_SKIP;
                emit      = 1'b1;
                e_kind    = K_START;
                e_address = 32'h0000_0000;
                e_fields  = 1'b0;
            end
        end else if (r_phase == PH_SKIP) begin
            if (cls.is_lf) begin
                n_phase = PH_IDLE;
            end
        end else if (cls.is_lf) begin
            n_phase = PH_IDLE;
            emit    = 1'b1;
            e_kind  = K_SHORT;
        end else if (!cls.is_hex) begin
            n_phase = PH_SKIP;
            emit    = 1'b1;
            e_kind  = K_HEX;
        end else if (!r_pending) begin
            n_high    = cls.nibble;
            n_pending = 1'b1;
        end else begin
            n_pending = 1'b0;
            n_sum     = r_sum + byte_val;
            unique case (r_phase)
                PH_COUNT: begin
                    n_count = byte_val;
                    n_phase = PH_ADDRH;
                end
                PH_ADDRH: begin
                    n_offset = {byte_val, 8'h00};
                    n_phase  = PH_ADDRL;
                end
                PH_ADDRL: begin
                    n_offset = {r_offset[15:8], byte_val};
                    n_phase  = PH_TYPE;
                end
                PH_TYPE: begin
                    n_type  = byte_val;
                    n_phase = (r_count != 8'h00) ? PH_DATA : PH_CHECK;
                end
                PH_DATA: begin
                    if (r_done == 8'h00) begin
                        n_first = {byte_val, r_first[7:0]};
                    end else if (r_done == 8'h01) begin
                        n_first = {r_first[15:8], byte_val};
                    end
                    if (r_type == TYPE_DATA) begin
                        emit      = 1'b1;
                        e_kind    = K_DATA;
                        e_address = rec_base + {24'h000000, r_done};
                        e_data    = byte_val;
                    end
                    n_done = done_inc;
                    if (done_inc == r_count) begin
                        n_phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    n_phase = PH_SKIP;
                    emit    = 1'b1;
                    if (n_sum != 8'h00) begin
                        e_kind = K_CSUM;
                    end else if (r_type == TYPE_EOF) begin
                        n_stopped = 1'b1;
                        e_kind    = K_EOF;
                    end else begin
                        e_kind = K_OK;
                        if (r_count >= 8'd2) begin
                            if (r_type == TYPE_LIN) begin
                                n_base = {r_first, 16'h0000};
                            end else if (r_type == TYPE_SEG) begin
                                n_base = {12'h000, r_first, 4'h0};
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_high    <= 4'h0;
            r_pending <= 1'b0;
            r_count   <= 8'h00;
            r_offset  <= 16'h0000;
            r_type    <= 8'h00;
            r_done    <= 8'h00;
            r_sum     <= 8'h00;
            r_base    <= 32'h0000_0000;
            r_first   <= 16'h0000;
            r_stopped <= 1'b0;
        end else if (accept) begin
            r_phase   <= n_phase;
            r_high    <= n_high;
            r_pending <= n_pending;
            r_count   <= n_count;
            r_offset  <= n_offset;
            r_type    <= n_type;
            r_done    <= n_done;
            r_sum     <= n_sum;
            r_base    <= n_base;
            r_first   <= n_first;
            r_stopped <= n_stopped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_kind      <= e_kind;
            r_address   <= e_address;
            r_data_byte <= e_data;
            r_rtype     <= e_fields ? r_type  : 8'h00;
            r_bcount    <= e_fields ? r_count : 8'h00;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_kind        = r_kind;
    assign o_address     = r_address;
    assign o_data_byte   = r_data_byte;
    assign o_record_type = r_rtype;
    assign o_byte_count  = r_bcount;

    a_stopped_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped && !r_out_valid |=> !r_out_valid)
        else $error("result after end of file");

    a_data_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == K_DATA |-> o_record_type == TYPE_DATA)
        else $error("data byte from non-data record");

    a_start_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == K_START |->
        o_address == 32'h0 && o_record_type == 8'h00 && o_byte_count == 8'h00)
        else $error("bad start item carries record fields");

    a_no_take_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_stall |=> r_out_valid && $stable(r_kind))
        else $error("held result lost");

endmodule

`default_nettype wire

// ===== design/hrp_char_class.sv =====
// ----------------------------------------------------------------------------
// hrp_char_class
// Classifies one ASCII character: whitespace, colon, LF, hex digit value.
// ----------------------------------------------------------------------------
`default_nettype none

module hrp_char_class
    import hrp_pkg::*;
(
    input  wire logic [7:0]  i_character,
    output t_char_class      o_class
);

    logic is_dec;
    logic is_lower;
    logic is_upper;
    logic [7:0] dec_val;
    logic [7:0] low_val;
    logic [7:0] up_val;

    always_comb begin
        is_dec   = (i_character >= 8'h30) && (i_character <= 8'h39);
        is_lower = (i_character >= 8'h61) && (i_character <= 8'h66);
        is_upper = (i_character >= 8'h41) && (i_character <= 8'h46);
        dec_val  = i_character - 8'h30;
        low_val  = i_character - 8'h57;
        up_val   = i_character - 8'h37;

        o_class.is_space = (i_character == 8'h20) ||
                           ((i_character >= 8'h09) && (i_character <= 8'h0D));
        o_class.is_colon = (i_character == CH_COLON);
        o_class.is_lf    = (i_character == CH_LF);
        o_class.is_hex   = is_dec || is_lower || is_upper;
        if (is_dec) begin
            o_class.nibble = dec_val[3:0];
        end else if (is_lower) begin
            o_class.nibble = low_val[3:0];
        end else begin
            o_class.nibble = up_val[3:0];
        end
    end

endmodule

`default_nettype wire
